>>> sv/bezier_easing_solver_unit_defines.svh
// Assertion macros for the cubic Bezier easing solver.
// Included by the top level; depends on nothing else.
`ifndef BEZIER_EASING_SOLVER_UNIT_DEFINES_SVH
`define BEZIER_EASING_SOLVER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define BES_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define BES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define BES_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define BES_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> sv/bes_pkg.sv
// Shared types, constants and fixed-point helpers of the Bezier easing solver.
// Used by bes_cell, bes_eval and bezier_easing_solver_unit; depends on nothing.
`timescale 1ns / 1ps

package bes_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int FIELD_W      = 17;
    localparam int TOL_W        = 16;
    localparam int W_V          = 28;
    localparam int MAX_ITER_DEF = 12;
    localparam int EVAL_STAGES  = 5;
    localparam int ONE_INT      = 1 << FRAC_BITS;

    localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(33);
    localparam logic [FIELD_W-1:0] ONE_F     = FIELD_W'(ONE_INT);

    typedef logic signed [W_V-1:0] t_val;

    localparam t_val ONE_V   = t_val'(ONE_INT);
    localparam t_val T_LIM   = t_val'(2 * ONE_INT);
    localparam t_val T_LIM_N = t_val'(-2 * ONE_INT);

    typedef struct packed {
        logic vld;
        logic done;
        t_val t;
    } t_cell_bus;

    typedef struct packed {
        t_val k0;
        t_val k1;
        t_val k2;
        t_val x;
        t_val tol;
    } t_coef;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_F2,
        PH_F3,
        PH_UPD
    } t_cell_ph;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_EVAL,
        ST_DONE
    } t_state;

    function automatic t_val uext_field(input logic [FIELD_W-1:0] v);
        return t_val'({{(W_V - FIELD_W){1'b0}}, v});
    endfunction

    function automatic t_val uext_tol(input logic [TOL_W-1:0] v);
        return t_val'({{(W_V - TOL_W){1'b0}}, v});
    endfunction

    // Fixed-point product; the arithmetic shift floors toward minus infinity.
    function automatic t_val mulq(input t_val a, input t_val b);
        logic signed [2*W_V-1:0] p;
        p = (2*W_V)'(a) * (2*W_V)'(b);
        return t_val'(p >>> FRAC_BITS);
    endfunction

    function automatic t_val sat_t(input t_val v);
        t_val r;
        r = v;
        if (v > T_LIM) begin
            r = T_LIM;
        end else if (v < T_LIM_N) begin
            r = T_LIM_N;
        end
        return r;
    endfunction

endpackage

>>> sv/bes_cell.sv
// One refinement cell of the chain: evaluates the x residual and steps t.
// Depends on bes_pkg.
`timescale 1ns / 1ps

module bes_cell
    import bes_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_bus i_prev,
    input  t_coef     i_coef,
    output t_cell_bus o_next
);

    t_cell_ph r_ph, n_ph;
    t_val     r_t, n_t;
    t_val     r_acc, n_acc;
    logic     r_vld, n_vld;
    logic     r_done, n_done;
    t_val     r_tout, n_tout;

    always_comb begin
        n_ph   = r_ph;
        n_t    = r_t;
        n_acc  = r_acc;
        n_vld  = 1'b0;
        n_done = r_done;
        n_tout = r_tout;
        unique case (r_ph)
            PH_IDLE: begin
                if (i_prev.vld) begin
                    if (i_prev.done) begin
                        n_vld  = 1'b1;
                        n_done = 1'b1;
                        n_tout = i_prev.t;
                    end else begin
                        n_t   = i_prev.t;
                        n_acc = mulq(i_coef.k0, i_prev.t) + i_coef.k1;
                        n_ph  = PH_F2;
                    end
                end
            end
            PH_F2: begin
                n_acc = mulq(r_acc, r_t) + i_coef.k2;
                n_ph  = PH_F3;
            end
            PH_F3: begin
                n_acc = mulq(r_acc, r_t) - i_coef.x;
                n_ph  = PH_UPD;
            end
            PH_UPD: begin
                n_vld = 1'b1;
                n_ph  = PH_IDLE;
                if (r_acc <= i_coef.tol && r_acc >= -i_coef.tol) begin
                    n_done = 1'b1;
                    n_tout = r_t;
                end else begin
                    n_done = 1'b0;
                    n_tout = sat_t(r_t - (r_acc >>> 1));
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= PH_IDLE;
            r_vld <= 1'b0;
        end else begin
            r_ph  <= n_ph;
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t    <= n_t;
        r_acc  <= n_acc;
        r_done <= n_done;
        r_tout <= n_tout;
    end

    assign o_next = '{vld: r_vld, done: r_done, t: r_tout};

endmodule

>>> sv/bes_eval.sv
// Five-stage pipeline that evaluates the curve y from the solved t and saturates it.
// Depends on bes_pkg.
`timescale 1ns / 1ps

module bes_eval
    import bes_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_val               i_t,
    input  t_val               i_c1y,
    input  t_val               i_c2y,
    output logic               o_done,
    output logic [FIELD_W-1:0] o_y
);

    logic [EVAL_STAGES-1:0] r_stg;

    t_val r1_t, r1_r, r1_t2;
    t_val r2_t, r2_t3, r2_r2, r2_a;
    t_val r3_t3, r3_b, r3_c;
    t_val r4_t3, r4_c3, r4_d;
    t_val w_y;
    logic [FIELD_W-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= '0;
        end else begin
            r_stg <= {r_stg[EVAL_STAGES-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_t  <= i_t;
        r1_r  <= ONE_V - i_t;
        r1_t2 <= mulq(i_t, i_t);

        r2_t  <= r1_t;
        r2_t3 <= mulq(r1_t2, r1_t);
        r2_r2 <= mulq(r1_r, r1_r);
        r2_a  <= mulq(r1_t2, r1_r);

        r3_t3 <= r2_t3;
        r3_b  <= mulq(r2_t, r2_r2);
        r3_c  <= mulq(r2_a, i_c2y);

        r4_t3 <= r3_t3;
        r4_c3 <= (r3_c <<< 1) + r3_c;
        r4_d  <= mulq(r3_b, i_c1y);
    end

    assign w_y = r4_t3 + r4_c3 + (r4_d <<< 1) + r4_d;

    always_ff @(posedge i_clk) begin
        if (r_stg[EVAL_STAGES-2]) begin
            if (w_y < 0) begin
                r_y <= '0;
            end else if (w_y > ONE_V) begin
                r_y <= ONE_F;
            end else begin
                r_y <= w_y[FIELD_W-1:0];
            end
        end
    end

    assign o_done = r_stg[EVAL_STAGES-1];
    assign o_y    = r_y;

endmodule

>>> sv/bezier_easing_solver_unit.sv
// Top level of the cubic Bezier easing solver: handshakes, control and the cell chain.
// Depends on bes_pkg, bes_cell, bes_eval and bezier_easing_solver_unit_defines.svh.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_stall   x_in, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
//   output   out        o_valid / i_stall   y_out, converged
//   config   in         i_cfg_wr_en         residual_tolerance
//
// One item is in flight at a time. Each refinement cell works a step as three chained
// multiplies and the update; after convergence a cell forwards the solved t unchanged.
// A diagonal curve bypasses the cell chain and the evaluator. A new transfer is taken
// while a result waits in the output register. Reset is synchronous and sets the
// tolerance to 33.
`timescale 1ns / 1ps
`include "bezier_easing_solver_unit_defines.svh"

module bezier_easing_solver_unit
    import bes_pkg::*;
#(
    parameter int MAX_ITER = MAX_ITER_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [TOL_W-1:0]   i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [FIELD_W-1:0] i_x_in,
    input  logic [FIELD_W-1:0] i_ctrl1_x,
    input  logic [FIELD_W-1:0] i_ctrl1_y,
    input  logic [FIELD_W-1:0] i_ctrl2_x,
    input  logic [FIELD_W-1:0] i_ctrl2_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [FIELD_W-1:0] o_y_out,
    output logic               o_converged
);

    t_state r_state, n_state;
    logic   r_start, n_start;
    logic   r_ovalid;
    logic   [TOL_W-1:0] r_tol;

    t_coef  r_coef;
    t_val   r_t0;
    t_val   r_c1y;
    t_val   r_c2y;
    logic   r_byp;
    logic   r_conv;
    logic   [FIELD_W-1:0] r_x_sat;
    logic   [FIELD_W-1:0] r_oy;
    logic   r_oconv;

    logic   w_accept;
    logic   w_byp_in;
    logic   w_load;
    logic   w_eval_done;
    logic   [FIELD_W-1:0] w_eval_y;
    t_coef  w_coef;

    t_cell_bus w_bus [MAX_ITER+1];

    assign w_accept = i_valid && !o_stall;
    assign w_byp_in = (i_ctrl1_x == i_ctrl1_y) && (i_ctrl2_x == i_ctrl2_y);
    assign o_stall  = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_start = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_byp_in) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_ITER;
                        n_start = 1'b1;
                    end
                end
            end
            ST_ITER: begin
                if (w_bus[MAX_ITER].vld) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (w_eval_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
            r_tol    <= TOL_RESET;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
        end
    end

    // Coefficients of the x polynomial in Horner form.
    always_comb begin
        w_coef.k0  = t_val'(ONE_V + 3 * uext_field(i_ctrl1_x) - 3 * uext_field(i_ctrl2_x));
        w_coef.k1  = t_val'(3 * uext_field(i_ctrl2_x) - 6 * uext_field(i_ctrl1_x));
        w_coef.k2  = t_val'(3 * uext_field(i_ctrl1_x));
        w_coef.x   = uext_field(i_x_in);
        w_coef.tol = uext_tol(r_tol);
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_coef  <= w_coef;
            r_t0    <= sat_t(uext_field(i_x_in));
            r_c1y   <= uext_field(i_ctrl1_y);
            r_c2y   <= uext_field(i_ctrl2_y);
            r_byp   <= w_byp_in;
            r_x_sat <= (i_x_in > ONE_F) ? ONE_F : i_x_in;
        end
        if (w_bus[MAX_ITER].vld) begin
            r_conv <= w_bus[MAX_ITER].done;
        end
        if (w_load) begin
            r_oy    <= r_byp ? r_x_sat : w_eval_y;
            r_oconv <= r_byp | r_conv;
        end
    end

    assign w_bus[0] = '{vld: r_start, done: 1'b0, t: r_t0};

    for (genvar gi = 0; gi < MAX_ITER; gi++) begin : g_cell
        bes_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_prev  (w_bus[gi]),
            .i_coef  (r_coef),
            .o_next  (w_bus[gi+1])
        );
    end

    bes_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bus[MAX_ITER].vld),
        .i_t     (w_bus[MAX_ITER].t),
        .i_c1y   (r_c1y),
        .i_c2y   (r_c2y),
        .o_done  (w_eval_done),
        .o_y     (w_eval_y)
    );

    assign o_valid     = r_ovalid;
    assign o_y_out     = r_oy;
    assign o_converged = r_oconv;

    `BES_ASSERT_IMP(a_chain_end_in_iter, i_clk, i_rst_n, w_bus[MAX_ITER].vld, r_state == ST_ITER)
    `BES_ASSERT_IMP(a_eval_end_in_eval, i_clk, i_rst_n, w_eval_done, r_state == ST_EVAL)
    `BES_ASSERT_NEXT(a_bypass_to_done, i_clk, i_rst_n, w_accept && w_byp_in, r_state == ST_DONE)
    `BES_ASSERT_IMP(a_out_in_range, i_clk, i_rst_n, o_valid, o_y_out <= ONE_F)

endmodule
